// ----- rtl/bbe_pkg.sv -----
// Shared types, constants and a helper function for the 3x3 edge-aware box blur.
`default_nettype none
package bbe_pkg;

	// Frame limits and the widths that follow from them.
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int WID_W      = COL_W + 1;
	localparam int HGT_W      = ROW_W + 1;
	localparam int CFG_W      = 13;
	localparam int CFG_IDX_W  = 2;

	// Pixel and arithmetic widths.
	localparam int PIX_W   = 8;
	localparam int RGB_W   = 3 * PIX_W;
	localparam int SUM_W   = 12;
	localparam int CNT_W   = 4;
	localparam int RCP_SH  = 16;
	localparam int RCP_W   = RCP_SH + 1;
	localparam int PROD_W  = SUM_W + RCP_W;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

	// Input word: one RGB pixel.
	typedef struct packed {
		logic [PIX_W-1:0] in_red;
		logic [PIX_W-1:0] in_green;
		logic [PIX_W-1:0] in_blue;
	} in_word_t;

	// Output word: one blurred pixel with its position.
	typedef struct packed {
		logic [PIX_W-1:0] out_red;
		logic [PIX_W-1:0] out_green;
		logic [PIX_W-1:0] out_blue;
		logic [ROW_W-1:0] out_row;
		logic [COL_W-1:0] out_col;
		logic             run_last;
	} out_word_t;

	// Reciprocal ceil(2^16 / n); exact truncated division for sums below 4096.
	function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] n);
		logic [RCP_W-1:0] r;
		case (n)
			4'd2:    r = 17'd32768;
			4'd3:    r = 17'd21846;
			4'd4:    r = 17'd16384;
			4'd5:    r = 17'd13108;
			4'd6:    r = 17'd10923;
			4'd7:    r = 17'd9363;
			4'd8:    r = 17'd8192;
			4'd9:    r = 17'd7282;
			default: r = 17'd65536;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/bbe_line_store.sv -----
// One line store: a single-port-write, registered-read memory of one image row.
`default_nettype none
module bbe_line_store (
	input  wire logic                        clk,
	input  wire logic                        wr_en,
	input  wire logic [bbe_pkg::COL_W-1:0]   wr_addr,
	input  wire logic [bbe_pkg::RGB_W-1:0]   wr_data,
	input  wire logic                        rd_en,
	input  wire logic [bbe_pkg::COL_W-1:0]   rd_addr,
	output logic      [bbe_pkg::RGB_W-1:0]   rd_data
);

	logic [bbe_pkg::RGB_W-1:0] mem_q [0:bbe_pkg::MAX_WIDTH-1];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/bbe_lane.sv -----
// One color lane: masked sum of the nine window samples, then division by reciprocal.
`default_nettype none
module bbe_lane (
	input  wire logic                       clk,
	input  wire logic                       sum_en,
	input  wire logic [bbe_pkg::PIX_W-1:0]  px [0:8],
	input  wire logic [8:0]                 mask,
	input  wire logic [bbe_pkg::RCP_W-1:0]  rcp,
	output logic      [bbe_pkg::PIX_W-1:0]  mean
);

	logic [bbe_pkg::SUM_W-1:0]  sum_d;
	logic [bbe_pkg::SUM_W-1:0]  sum_s1;
	logic [bbe_pkg::PROD_W-1:0] prod;

	// Sum of the samples that lie inside the image.
	always_comb begin
		sum_d = '0;
		for (int i = 0; i < 9; i++) begin
			if (mask[i]) begin
				sum_d = sum_d + {{(bbe_pkg::SUM_W-bbe_pkg::PIX_W){1'b0}}, px[i]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sum_en) begin
			sum_s1 <= sum_d;
		end
	end

	// Multiply by the reciprocal and keep the integer part.
	assign prod = {{bbe_pkg::RCP_W{1'b0}}, sum_s1} * {{bbe_pkg::SUM_W{1'b0}}, rcp};
	assign mean = prod[bbe_pkg::RCP_SH +: bbe_pkg::PIX_W];

endmodule
`default_nettype wire

// ----- rtl/box_blur_3x3_edge_aware_unit.sv -----
// Top level of the streaming 3x3 edge-aware box blur.
//
//  Channel | Direction | Handshake            | Word
//  in      | input     | in_valid / in_ready  | bbe_pkg::in_word_t
//  out     | output    | out_valid / out_ready| bbe_pkg::out_word_t
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// An input word takes a load step, set by the line store read, and then, for each
// of the k results it completes (up to four), the shared sum/divide step that the
// three color lanes run once per result; the input stays closed until it is done.
// Reset clears the position counters, the window history and the handshake state.
// A stalled output holds its word in the output register; the block takes the
// next pixel while that word still waits.
`default_nettype none
module box_blur_3x3_edge_aware_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire bbe_pkg::in_word_t               in_data,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output bbe_pkg::out_word_t                   out_data,
	input  wire logic                            cfg_we,
	input  wire logic [bbe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [bbe_pkg::CFG_W-1:0]       cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_SUM  = 2'd2;
	localparam logic [1:0] ST_DIV  = 2'd3;

	logic [1:0]                      state_q;
	logic [bbe_pkg::WID_W-1:0]       width_q;
	logic [bbe_pkg::HGT_W-1:0]       height_q;
	logic [bbe_pkg::ROW_W-1:0]       row_q;
	logic [bbe_pkg::COL_W-1:0]       col_q;
	logic [bbe_pkg::ROW_W-1:0]       rin_q;
	logic [bbe_pkg::COL_W-1:0]       cin_q;
	logic [bbe_pkg::RGB_W-1:0]       pix_q;
	logic [bbe_pkg::RGB_W-1:0]       hist_q [0:5];
	logic [bbe_pkg::RGB_W-1:0]       win_q  [0:8];
	logic [3:0]                      pend_q;
	logic [bbe_pkg::RGB_W-1:0]       up_rd;
	logic [bbe_pkg::RGB_W-1:0]       mid_rd;
	logic                            in_acc;
	logic                            load;
	logic                            col_last;
	logic                            row_last;
	logic [3:0]                      pend_d;
	logic [3:0]                      sel;
	logic                            sel_a;
	logic                            sel_b;
	logic [8:0]                      mask;
	logic [bbe_pkg::CNT_W-1:0]       cnt;
	logic [bbe_pkg::RCP_W-1:0]       rcp_s1;
	logic [bbe_pkg::ROW_W-1:0]       row_s1;
	logic [bbe_pkg::COL_W-1:0]       col_s1;
	logic                            last_s1;
	logic [bbe_pkg::PIX_W-1:0]       mean [0:2];
	logic [bbe_pkg::PIX_W-1:0]       lane_px [0:2][0:8];
	logic [bbe_pkg::WID_W-1:0]       cfg_w;
	logic [bbe_pkg::HGT_W-1:0]       cfg_h;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign load     = (state_q == ST_DIV) && (!out_valid || out_ready);
	assign col_last = ({1'b0, cin_q} == (width_q - 11'd1));
	assign row_last = ({1'b0, rin_q} == (height_q - 13'd1));

	// Line stores: rows r-2 and r-1 at each column.
	bbe_line_store u_upper (
		.clk     (clk),
		.wr_en   (state_q == ST_LOAD),
		.wr_addr (cin_q),
		.wr_data (mid_rd),
		.rd_en   (in_acc),
		.rd_addr (col_q),
		.rd_data (up_rd)
	);

	bbe_line_store u_middle (
		.clk     (clk),
		.wr_en   (state_q == ST_LOAD),
		.wr_addr (cin_q),
		.wr_data (pix_q),
		.rd_en   (in_acc),
		.rd_addr (col_q),
		.rd_data (mid_rd)
	);

	// Results that this pixel completes, in emission order.
	always_comb begin
		pend_d[0] = (rin_q != '0) && (cin_q != '0);
		pend_d[1] = (rin_q != '0) && col_last;
		pend_d[2] = row_last && (cin_q != '0);
		pend_d[3] = row_last && col_last;
	end

	// Pick the first pending result and its neighbor mask.
	always_comb begin
		if (pend_q[0]) begin
			sel = 4'b0001;
		end else if (pend_q[1]) begin
			sel = 4'b0010;
		end else if (pend_q[2]) begin
			sel = 4'b0100;
		end else begin
			sel = 4'b1000;
		end
		sel_a = sel[2] || sel[3];
		sel_b = sel[1] || sel[3];
		cnt   = '0;
		for (int wr = 0; wr < 3; wr++) begin
			for (int wc = 0; wc < 3; wc++) begin
				mask[wr*3+wc] = ((wr >= 1) || !sel_a)
					&& ((wc >= 1) || !sel_b)
					&& ((wr == 2) || ((wr == 1) && (rin_q >= 12'd1)) || (rin_q >= 12'd2))
					&& ((wc == 2) || ((wc == 1) && (cin_q >= 10'd1)) || (cin_q >= 10'd2));
				cnt = cnt + {3'd0, mask[wr*3+wc]};
			end
		end
	end

	// Three color lanes share the window and mask.
	for (genvar g = 0; g < 3; g++) begin : g_lane
		for (genvar k = 0; k < 9; k++) begin : g_px
			assign lane_px[g][k] = win_q[k][(2-g)*bbe_pkg::PIX_W +: bbe_pkg::PIX_W];
		end
		bbe_lane u_lane (
			.clk    (clk),
			.sum_en (state_q == ST_SUM),
			.px     (lane_px[g]),
			.mask   (mask),
			.rcp    (rcp_s1),
			.mean   (mean[g])
		);
	end

	// Clamped register values.
	always_comb begin
		cfg_w = cfg_data[bbe_pkg::WID_W-1:0];
		if (cfg_w == '0) begin
			cfg_w = 11'd1;
		end else if (cfg_w > 11'(bbe_pkg::MAX_WIDTH)) begin
			cfg_w = 11'(bbe_pkg::MAX_WIDTH);
		end
		cfg_h = cfg_data[bbe_pkg::HGT_W-1:0];
		if (cfg_h == '0) begin
			cfg_h = 13'd1;
		end else if (cfg_h > 13'(bbe_pkg::MAX_HEIGHT)) begin
			cfg_h = 13'(bbe_pkg::MAX_HEIGHT);
		end
	end

	// Sequencer, positions, window history and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			width_q  <= 11'(bbe_pkg::MAX_WIDTH);
			height_q <= 13'd768;
			row_q    <= '0;
			col_q    <= '0;
			pend_q   <= '0;
			for (int i = 0; i < 6; i++) begin
				hist_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					for (int i = 0; i < 3; i++) begin
						hist_q[i] <= hist_q[3+i];
					end
					hist_q[3] <= up_rd;
					hist_q[4] <= mid_rd;
					hist_q[5] <= pix_q;
					if (col_last) begin
						col_q <= '0;
						row_q <= row_last ? '0 : rin_q + 12'd1;
					end else begin
						col_q <= cin_q + 10'd1;
					end
					pend_q  <= pend_d;
					state_q <= (pend_d != '0) ? ST_SUM : ST_IDLE;
				end
				ST_SUM: begin
					pend_q  <= pend_q & ~sel;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (load) begin
						state_q <= (pend_q != '0) ? ST_SUM : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_we && (cfg_index == bbe_pkg::CFG_FRAME_WIDTH
				|| cfg_index == bbe_pkg::CFG_FRAME_HEIGHT)) begin
				if (cfg_index == bbe_pkg::CFG_FRAME_WIDTH) begin
					width_q <= cfg_w;
				end else begin
					height_q <= cfg_h;
				end
				row_q <= '0;
				col_q <= '0;
				for (int i = 0; i < 6; i++) begin
					hist_q[i] <= '0;
				end
			end
		end
	end

	// Captured pixel, position and assembled window.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_q <= {in_data.in_red, in_data.in_green, in_data.in_blue};
			rin_q <= row_q;
			cin_q <= col_q;
		end
		if (state_q == ST_LOAD) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i*3]   <= hist_q[i];
				win_q[i*3+1] <= hist_q[3+i];
			end
			win_q[2] <= up_rd;
			win_q[5] <= mid_rd;
			win_q[8] <= pix_q;
		end
		if (state_q == ST_SUM) begin
			rcp_s1  <= bbe_pkg::recip(cnt);
			row_s1  <= sel_a ? rin_q : rin_q - 12'd1;
			col_s1  <= sel_b ? cin_q : cin_q - 10'd1;
			last_s1 <= ((pend_q & ~sel) == '0);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data.out_red   <= mean[0];
			out_data.out_green <= mean[1];
			out_data.out_blue  <= mean[2];
			out_data.out_row   <= row_s1;
			out_data.out_col   <= col_s1;
			out_data.run_last  <= last_s1;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/bbe_checker.sv -----
// Port-level checker for the box blur top level, with its bind statement.
`default_nettype none
module bbe_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire bbe_pkg::out_word_t out_data
);

	// A stalled output word stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	// An accepted pixel keeps the input closed for the following cycle.
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after an accepted pixel");

	// Reset leaves no output word pending.
	a_rst_out: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("output valid after reset");

	// A result never shows a column past the frame limit.
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.out_col <= 10'(bbe_pkg::MAX_WIDTH - 1)))
		else $error("output column out of range");

endmodule

bind box_blur_3x3_edge_aware_unit bbe_checker u_bbe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire

// ----- tb/box_blur_3x3_edge_aware_unit_test.sv -----
// Self-checking testbench for the streaming 3x3 edge-aware box blur.
`timescale 1ns / 100ps
`default_nettype none
module box_blur_3x3_edge_aware_unit_test;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	bbe_pkg::in_word_t             in_data;
	logic                          out_valid;
	logic                          out_ready;
	bbe_pkg::out_word_t            out_data;
	logic                          cfg_we;
	logic [bbe_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [bbe_pkg::CFG_W-1:0]     cfg_data;

	box_blur_3x3_edge_aware_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Pixels waiting to be sent and blurred pixels waiting to come out.
	bbe_pkg::in_word_t  pixel_q[$];
	bbe_pkg::out_word_t blurred_q[$];
	int                 mismatches = 0;
	bit                 calm = 0;

	// Predictor state: line stores, window columns, position and frame size.
	logic [bbe_pkg::RGB_W-1:0] upper_store[bbe_pkg::MAX_WIDTH];
	logic [bbe_pkg::RGB_W-1:0] middle_store[bbe_pkg::MAX_WIDTH];
	logic [bbe_pkg::RGB_W-1:0] win_cols[6];
	int                        next_row, next_col;
	int                        img_w_reg, img_h_reg;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// Register write in the model: restart the frame, keep the line stores.
	task automatic apply_frame_reg(input logic [bbe_pkg::CFG_IDX_W-1:0] idx, input int val);
		if (idx == bbe_pkg::CFG_FRAME_WIDTH)
			img_w_reg = val & 11'h7FF;
		else
			img_h_reg = val & 13'h1FFF;
		next_row = 0;
		next_col = 0;
		foreach (win_cols[i]) win_cols[i] = '0;
	endtask

	// Mean of the in-frame neighbors of (pr, pc), taken from the 3x3 window.
	function automatic bbe_pkg::out_word_t mean_of(
			input logic [bbe_pkg::RGB_W-1:0] win[3][3],
			input int r, input int c, input int pr, input int pc,
			input int w, input int h);
		bbe_pkg::out_word_t o;
		int sr, sg, sb, n, nr, nc, wr, wc;
		sr = 0; sg = 0; sb = 0; n = 0;
		for (int dr = -1; dr <= 1; dr++)
			for (int dc = -1; dc <= 1; dc++) begin
				nr = pr + dr;
				nc = pc + dc;
				wr = nr - (r - 2);
				wc = nc - (c - 2);
				if (nr >= 0 && nr < h && nc >= 0 && nc < w &&
						wr >= 0 && wr <= 2 && wc >= 0 && wc <= 2) begin
					sr += win[wr][wc][23:16];
					sg += win[wr][wc][15:8];
					sb += win[wr][wc][7:0];
					n++;
				end
			end
		if (n == 0) n = 1;
		o.out_red   = 8'(sr / n);
		o.out_green = 8'(sg / n);
		o.out_blue  = 8'(sb / n);
		o.out_row   = 12'(pr);
		o.out_col   = 10'(pc);
		o.run_last  = 1'b0;
		return o;
	endfunction

	// Take one pixel into the model and queue the blurred pixels it completes.
	task automatic blur_pixel(input bbe_pkg::in_word_t px);
		logic [bbe_pkg::RGB_W-1:0] win[3][3];
		int w, h, r, c, made;
		w = (img_w_reg < 1) ? 1 :
			(img_w_reg > bbe_pkg::MAX_WIDTH) ? bbe_pkg::MAX_WIDTH : img_w_reg;
		h = (img_h_reg < 1) ? 1 :
			(img_h_reg > bbe_pkg::MAX_HEIGHT) ? bbe_pkg::MAX_HEIGHT : img_h_reg;
		if (next_row >= h) next_row = 0;
		if (next_col >= w) next_col = 0;
		r = next_row;
		c = next_col;
		made = 0;
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win_cols[i];
			win[i][1] = win_cols[3 + i];
		end
		win[0][2] = upper_store[c];
		win[1][2] = middle_store[c];
		win[2][2] = px;
		upper_store[c] = middle_store[c];
		middle_store[c] = px;
		for (int i = 0; i < 3; i++) begin
			win_cols[i] = win_cols[3 + i];
			win_cols[3 + i] = win[i][2];
		end
		if (r >= 1 && c >= 1) begin
			blurred_q.push_back(mean_of(win, r, c, r - 1, c - 1, w, h)); made++;
		end
		if (r >= 1 && c == w - 1) begin
			blurred_q.push_back(mean_of(win, r, c, r - 1, c, w, h)); made++;
		end
		if (r == h - 1 && c >= 1) begin
			blurred_q.push_back(mean_of(win, r, c, r, c - 1, w, h)); made++;
		end
		if (r == h - 1 && c == w - 1) begin
			blurred_q.push_back(mean_of(win, r, c, r, c, w, h)); made++;
		end
		if (made > 0) blurred_q[$].run_last = 1'b1;
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) r = 0;
		end
		next_row = r;
		next_col = c;
	endtask

	// Clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Pixel driver: sends queued words, with random idle bursts.
	int                in_gap;
	logic              nxt_in_valid;
	bbe_pkg::in_word_t nxt_in_data;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
			in_gap   <= 0;
		end else begin
			nxt_in_valid = in_valid;
			nxt_in_data  = in_data;
			if (in_valid && in_ready) begin
				blur_pixel(in_data);
				nxt_in_valid = 1'b0;
			end
			if (!nxt_in_valid) begin
				if (in_gap > 0)
					in_gap <= in_gap - 1;
				else if (pixel_q.size() > 0) begin
					if (!calm && $urandom_range(0, 5) == 0)
						in_gap <= $urandom_range(1, 11);
					else begin
						nxt_in_valid = 1'b1;
						nxt_in_data  = pixel_q.pop_front();
					end
				end
			end
			in_valid <= nxt_in_valid;
			in_data  <= nxt_in_data;
		end
	end

	// Result monitor: compares each accepted word with the oldest expectation and stalls out_ready at random.
	int                 out_stall;
	bbe_pkg::out_word_t exp_word;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_stall <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (blurred_q.size() == 0)
					report_mismatch("unexpected output word");
				else begin
					exp_word = blurred_q.pop_front();
					if (out_data.out_row !== exp_word.out_row ||
							out_data.out_col !== exp_word.out_col)
						report_mismatch($sformatf("position %0d,%0d expected %0d,%0d",
							out_data.out_row, out_data.out_col,
							exp_word.out_row, exp_word.out_col));
					if (out_data.out_red !== exp_word.out_red ||
							out_data.out_green !== exp_word.out_green ||
							out_data.out_blue !== exp_word.out_blue)
						report_mismatch($sformatf("pixel %0d,%0d rgb %h expected %h",
							exp_word.out_row, exp_word.out_col,
							{out_data.out_red, out_data.out_green, out_data.out_blue},
							{exp_word.out_red, exp_word.out_green, exp_word.out_blue}));
					if (out_data.run_last !== exp_word.run_last)
						report_mismatch($sformatf("run_last at %0d,%0d is %b",
							exp_word.out_row, exp_word.out_col, out_data.run_last));
				end
			end
			if (out_stall > 0) begin
				out_stall <= out_stall - 1;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_stall <= $urandom_range(0, 10);
				out_ready <= 1'b0;
			end else
				out_ready <= 1'b1;
		end
	end

	// Wait until every pixel is sent and every blurred pixel has come back.
	task automatic drain();
		while (pixel_q.size() > 0 || in_valid || blurred_q.size() > 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(input logic [bbe_pkg::CFG_IDX_W-1:0] idx, input int val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= 13'(val);
		apply_frame_reg(idx, val);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_frame(input int w, input int h);
		write_reg(bbe_pkg::CFG_FRAME_WIDTH, w);
		write_reg(bbe_pkg::CFG_FRAME_HEIGHT, h);
	endtask

	task automatic push_random(input int n);
		for (int i = 0; i < n; i++)
			pixel_q.push_back(bbe_pkg::in_word_t'(24'($urandom_range(0, 24'hFFFFFF))));
	endtask

	// Stimulus: directed frames first, then random frame shapes.
	int sent, n, w, h;
	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = bbe_pkg::CFG_FRAME_WIDTH;
		cfg_data  = '0;
		img_w_reg = 1024;
		img_h_reg = 768;
		next_row  = 0;
		next_col  = 0;
		foreach (win_cols[i]) win_cols[i] = '0;
		foreach (upper_store[i]) begin
			upper_store[i]  = '0;
			middle_store[i] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Reset frame size: a few pixels of the first row complete nothing.
		pixel_q.push_back(24'h000000);
		pixel_q.push_back(24'hFFFFFF);
		push_random(3);
		drain();

		// Zero width and height act as a one-pixel image.
		set_frame(0, 0);
		pixel_q.push_back(24'h000000);
		pixel_q.push_back(24'hFFFFFF);
		push_random(2);
		drain();

		// One column, oversized height clamped to the maximum.
		set_frame(1, 8191);
		push_random(8);
		drain();

		// 3x3 image of saturated and zero pixels: divisors 4, 6 and 9, and every edge.
		set_frame(3, 3);
		for (int i = 0; i < 9; i++)
			pixel_q.push_back((i % 2) ? 24'hFFFFFF : 24'h000000);
		push_random(9);
		drain();

		// A width value past the register field keeps only its low bits.
		set_frame(2051, 2);
		push_random(6);
		drain();

		// Random frame shapes: whole frames mostly, some cut short.
		sent = 0;
		while (sent < 110) begin
			if (sent > 80) calm = 1;
			w = $urandom_range(1, 9);
			h = $urandom_range(1, 8);
			set_frame(w, h);
			if ($urandom_range(0, 4) == 0)
				n = $urandom_range(1, w * h);
			else
				n = w * h * $urandom_range(1, 2);
			if (n > 115 - sent) n = 115 - sent;
			push_random(n);
			sent += n;
			drain();
		end

		if (mismatches == 0)
			$display("PASS box_blur_3x3_edge_aware_unit");
		else
			$display("FAIL box_blur_3x3_edge_aware_unit");
		$finish;
	end

	// Watchdog.
	initial begin
		#1500000;
		$display("FAIL box_blur_3x3_edge_aware_unit");
		$finish;
	end

endmodule
`default_nettype wire

// ----- files.f -----
rtl/bbe_pkg.sv
rtl/bbe_line_store.sv
rtl/bbe_lane.sv
rtl/box_blur_3x3_edge_aware_unit.sv
rtl/bbe_checker.sv
tb/box_blur_3x3_edge_aware_unit_test.sv
